// ===== sv/gpm_pkg.sv =====
// Shared types and constants of the granular grain pool mixer.
package gpm_pkg;

   localparam int DIV_W     = 23;   // divider remainder width, holds twice a ramp denominator
   localparam int REM_NUM_W = 17;   // dividend bits shifted in for a remainder
   localparam int FRAC_BITS = 15;   // quotient bits of an envelope ramp
   localparam int STEP_W    = 5;    // divider step counter

   localparam logic [6:0]  PERCENT_FULL = 7'd100;
   localparam logic [15:0] ENV_ONE      = 16'h8000;
   localparam logic [23:0] MIX_MAX      = 24'h7FFFFF;
   localparam logic [23:0] MIX_MIN      = 24'h800000;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [1:0] CSR_ATTACK  = 2'd0;
   localparam logic [1:0] CSR_RELEASE = 2'd1;
   localparam logic [1:0] CSR_STEP    = 2'd2;
   localparam logic [1:0] CSR_BLEN    = 2'd3;

   localparam logic [5:0]  ATTACK_RESET  = 6'd20;
   localparam logic [5:0]  RELEASE_RESET = 6'd20;
   localparam logic [4:0]  STEP_RESET    = 5'd1;
   localparam logic [16:0] BLEN_RESET    = 17'd65536;

   typedef struct packed {
      logic              cmd;
      logic [15:0]       write_address;
      logic signed [15:0] write_sample;
      logic              launch;
      logic [15:0]       grain_length;
      logic [15:0]       grain_start;
   } req_type;

   typedef struct packed {
      logic signed [23:0] mixed_sample;
      logic [4:0]         grain_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0]       win_start;
      logic [15:0]       win_len;
      logic [15:0]       offset;
      logic [5:0]        att_pct;
      logic [5:0]        rel_pct;
      logic signed [4:0] step;
   } grain_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_LAUNCH, ST_CHECK, ST_LOAD, ST_ADDR, ST_WRAP,
      ST_ENVP, ST_ENV, ST_FRAC, ST_MUL, ST_ACC, ST_DONE
   } state_type;

   typedef enum logic {DIV_REM, DIV_FRAC} div_mode_type;

   typedef struct packed {
      logic take_tick;
      logic store_wr;
      logic sum_clear;
      logic launch;
      logic found;
      logic grain_rd;
      logic div_pos;
      logic store_rd;
      logic div_wrap;
      logic wrap_take;
      logic env_prep;
      logic env_start;
      logic weight_take;
      logic mul;
      logic acc;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_active;
      logic is_last;
      logic div_done;
      logic env_flat;
   } ctrl_status_type;

endpackage

// ===== sv/gpm_div.sv =====
// Shared iterative divider: remainder of a 17-bit dividend, or a Q0.15 ratio below one.
module gpm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  gpm_pkg::div_mode_type        mode,
   input  logic [gpm_pkg::DIV_W-1:0]    num,
   input  logic [gpm_pkg::DIV_W-1:0]    den,
   output logic                         done,
   output logic [gpm_pkg::DIV_W-1:0]    rem,
   output logic [gpm_pkg::FRAC_BITS-1:0] quo
);

   logic                            run_ff, run_in;
   logic                            done_ff, done_in;
   logic [gpm_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [gpm_pkg::DIV_W-1:0]       r_ff, r_in;
   logic [gpm_pkg::DIV_W-1:0]       d_ff, d_in;
   logic [gpm_pkg::FRAC_BITS-1:0]   q_ff, q_in;
   logic [gpm_pkg::REM_NUM_W-1:0]   n_ff, n_in;
   gpm_pkg::div_mode_type           mode_ff, mode_in;
   logic [gpm_pkg::DIV_W-1:0]       trial;
   logic                            ge;

   always_comb begin
      trial = (mode_ff == gpm_pkg::DIV_REM) ?
              {r_ff[gpm_pkg::DIV_W-2:0], n_ff[gpm_pkg::REM_NUM_W-1]} :
              {r_ff[gpm_pkg::DIV_W-2:0], 1'b0};
      ge      = (trial >= d_ff);
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      n_in    = n_ff;
      mode_in = mode_ff;
      if (start) begin
         mode_in = mode;
         d_in    = den;
         q_in    = '0;
         if (mode == gpm_pkg::DIV_REM) begin
            if (num < den) begin
               // already reduced: finish at once
               r_in    = num;
               done_in = 1'b1;
               run_in  = 1'b0;
            end else begin
               r_in    = '0;
               n_in    = num[gpm_pkg::REM_NUM_W-1:0];
               step_in = gpm_pkg::STEP_W'(gpm_pkg::REM_NUM_W);
               run_in  = 1'b1;
            end
         end else begin
            r_in    = num;
            step_in = gpm_pkg::STEP_W'(gpm_pkg::FRAC_BITS);
            run_in  = 1'b1;
         end
      end else if (run_ff) begin
         r_in    = ge ? trial - d_ff : trial;
         q_in    = {q_ff[gpm_pkg::FRAC_BITS-2:0], ge};
         n_in    = {n_ff[gpm_pkg::REM_NUM_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == gpm_pkg::STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
      n_ff    <= n_in;
      mode_ff <= mode_in;
   end

   assign done = done_ff;
   assign rem  = r_ff;
   assign quo  = q_ff;

endmodule

// ===== sv/gpm_dp.sv =====
// Datapath: sample store, grain records, divider, envelope and mix accumulator.
module gpm_dp #(
   parameter int GRAIN_SLOTS = 16,
   parameter int STORE_DEPTH = 65536,
   parameter int SAMPLE_BITS = 16,
   parameter int SLOT_W      = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gpm_pkg::req_type          req_data,
   input  gpm_pkg::ctrl_cmd_type     cmd,
   input  logic [SLOT_W-1:0]         slot,
   input  logic                      csr_we,
   input  logic [1:0]                csr_idx,
   input  logic [16:0]               csr_wdata,
   output gpm_pkg::ctrl_status_type  status,
   output logic                      rsp_valid,
   output gpm_pkg::rsp_type          rsp_data
);

   localparam int AW      = $clog2(STORE_DEPTH);
   localparam int CNT_W   = $clog2(GRAIN_SLOTS + 1);
   localparam int PROD_W  = SAMPLE_BITS + 17;
   localparam int SUM_W   = SAMPLE_BITS + SLOT_W + 2;
   localparam int EXT_W   = (SUM_W > 25) ? SUM_W : 25;
   localparam logic signed [EXT_W-1:0] MIX_HI = EXT_W'(8388607);
   localparam logic signed [EXT_W-1:0] MIX_LO = EXT_W'(-8388608);

   // configuration
   logic [5:0]         cfg_att_ff, cfg_rel_ff;
   logic [4:0]         cfg_step_ff;
   logic [16:0]        cfg_blen_ff;
   logic [16:0]        blen;

   gpm_pkg::req_type   req_ff;

   logic [SAMPLE_BITS-1:0]  store_mem [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0]  smp_ff;
   gpm_pkg::grain_type      grain_mem [GRAIN_SLOTS];
   gpm_pkg::grain_type      rec_ff, new_rec, upd_rec, gm_wdata;
   logic                    gm_we;

   logic [GRAIN_SLOTS-1:0]  active_ff, active_in, pending_ff, pending_in;
   logic [SLOT_W-1:0]       highest_ff, highest_in, highest_new;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic signed [17:0]      raw_ff;
   logic [16:0]             raw_mag;
   logic [16:0]             pos;
   logic [15:0]             off_ff, off_new, rem_low;
   logic                    wrap;
   logic [22:0]             p_ff, rl100_ff, l100_ff;
   logic [21:0]             al_ff, rl_ff;
   logic                    ramp_up, ramp_dn, env_flat;
   logic [15:0]             weight_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [EXT_W-1:0] sum_ext;
   logic                    rsp_valid_ff;
   gpm_pkg::rsp_type        rsp_ff;

   logic                         div_start, div_done;
   gpm_pkg::div_mode_type        div_mode;
   logic [gpm_pkg::DIV_W-1:0]    div_num, div_den, div_rem;
   logic [gpm_pkg::FRAC_BITS-1:0] div_quo;

   gpm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mode  (div_mode),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .rem   (div_rem),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_att_ff  <= gpm_pkg::ATTACK_RESET;
         cfg_rel_ff  <= gpm_pkg::RELEASE_RESET;
         cfg_step_ff <= gpm_pkg::STEP_RESET;
         cfg_blen_ff <= gpm_pkg::BLEN_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            gpm_pkg::CSR_ATTACK:  cfg_att_ff  <= csr_wdata[5:0];
            gpm_pkg::CSR_RELEASE: cfg_rel_ff  <= csr_wdata[5:0];
            gpm_pkg::CSR_STEP:    cfg_step_ff <= csr_wdata[4:0];
            gpm_pkg::CSR_BLEN:    cfg_blen_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the buffer length into 1..STORE_DEPTH
   always_comb begin
      if (cfg_blen_ff == 17'd0)
         blen = 17'd1;
      else if (32'(cfg_blen_ff) > 32'(STORE_DEPTH))
         blen = 17'(STORE_DEPTH);
      else
         blen = cfg_blen_ff;
   end

   // grain arithmetic
   always_comb begin
      pos     = {1'b0, rec_ff.win_start} + {1'b0, rec_ff.offset};
      raw_mag = raw_ff[17] ? 17'(-raw_ff) : 17'(raw_ff);
      rem_low = div_rem[15:0];
      if (raw_ff[17])
         off_new = (rem_low == 16'd0) ? 16'd0 : rec_ff.win_len - rem_low;
      else
         off_new = rem_low;
      wrap = raw_ff[17] || (raw_ff >= $signed({2'b00, rec_ff.win_len}));

      new_rec.win_start = req_ff.grain_start;
      new_rec.win_len   = (req_ff.grain_length == 16'd0) ? 16'd1 : req_ff.grain_length;
      new_rec.offset    = 16'd0;
      new_rec.att_pct   = cfg_att_ff;
      new_rec.rel_pct   = cfg_rel_ff;
      new_rec.step      = cfg_step_ff;
      upd_rec           = rec_ff;
      upd_rec.offset    = off_new;
      gm_we             = cmd.launch | cmd.wrap_take;
      gm_wdata          = cmd.launch ? new_rec : upd_rec;

      ramp_up  = (rec_ff.att_pct != 6'd0) && (p_ff < {1'b0, al_ff});
      ramp_dn  = (rec_ff.rel_pct != 6'd0) && (p_ff > rl100_ff);
      env_flat = !ramp_up && !ramp_dn;
   end

   always_comb begin
      div_start = 1'b0;
      div_mode  = gpm_pkg::DIV_REM;
      div_num   = '0;
      div_den   = '0;
      if (cmd.div_pos) begin
         div_start = 1'b1;
         div_num   = gpm_pkg::DIV_W'(pos);
         div_den   = gpm_pkg::DIV_W'(blen);
      end else if (cmd.div_wrap) begin
         div_start = 1'b1;
         div_num   = gpm_pkg::DIV_W'(raw_mag);
         div_den   = gpm_pkg::DIV_W'(rec_ff.win_len);
      end else if (cmd.env_start && !env_flat) begin
         div_start = 1'b1;
         div_mode  = gpm_pkg::DIV_FRAC;
         div_num   = ramp_up ? p_ff : l100_ff - p_ff;
         div_den   = ramp_up ? gpm_pkg::DIV_W'(al_ff) : gpm_pkg::DIV_W'(rl_ff);
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.store_wr)
         store_mem[AW'(req_data.write_address)] <= SAMPLE_BITS'(req_data.write_sample);
      if (cmd.store_rd)
         smp_ff <= store_mem[AW'(div_rem)];
   end

   always_ff @(posedge clock) begin
      if (gm_we)
         grain_mem[slot] <= gm_wdata;
      if (cmd.grain_rd)
         rec_ff <= grain_mem[slot];
   end

   // slot flags and counts
   always_comb begin
      active_in   = active_ff;
      pending_in  = pending_ff;
      count_in    = count_ff;
      highest_new = (cmd.found && slot > highest_ff) ? slot : highest_ff;
      highest_in  = highest_ff;
      if (cmd.launch) begin
         highest_in = highest_new;
         for (int i = 0; i < GRAIN_SLOTS; i++) begin
            if (SLOT_W'(i) <= highest_new && SLOT_W'(i) != slot && active_ff[i])
               pending_in[i] = 1'b1;
         end
         active_in[slot]  = 1'b1;
         pending_in[slot] = 1'b0;
         if (cmd.found)
            count_in = count_ff + 1'b1;
      end else if (cmd.wrap_take && wrap && pending_ff[slot]) begin
         // drop the grain at its wrap
         active_in[slot] = 1'b0;
         count_in        = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         pending_ff   <= '0;
         highest_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         highest_ff   <= highest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign sum_ext = EXT_W'(sum_ff);

   always_ff @(posedge clock) begin
      if (cmd.take_tick)
         req_ff <= req_data;
      if (cmd.div_pos)
         raw_ff <= $signed({2'b00, rec_ff.offset}) + 18'(rec_ff.step);
      if (cmd.wrap_take)
         off_ff <= off_new;
      if (cmd.env_prep) begin
         p_ff     <= 23'(off_ff) * 23'(gpm_pkg::PERCENT_FULL);
         al_ff    <= 22'(rec_ff.att_pct) * 22'(rec_ff.win_len);
         rl100_ff <= 23'(gpm_pkg::PERCENT_FULL - 7'(rec_ff.rel_pct)) * 23'(rec_ff.win_len);
         rl_ff    <= 22'(rec_ff.rel_pct) * 22'(rec_ff.win_len);
         l100_ff  <= 23'(rec_ff.win_len) * 23'(gpm_pkg::PERCENT_FULL);
      end
      if (cmd.env_start && env_flat)
         weight_ff <= gpm_pkg::ENV_ONE;
      else if (cmd.weight_take)
         weight_ff <= 16'(div_quo);
      if (cmd.mul)
         prod_ff <= $signed(smp_ff) * $signed({1'b0, weight_ff});
      if (cmd.sum_clear)
         sum_ff <= '0;
      else if (cmd.acc)
         sum_ff <= sum_ff + SUM_W'(prod_ff >>> gpm_pkg::FRAC_BITS);
      if (cmd.finish) begin
         if (sum_ext > MIX_HI)
            rsp_ff.mixed_sample <= gpm_pkg::MIX_MAX;
         else if (sum_ext < MIX_LO)
            rsp_ff.mixed_sample <= gpm_pkg::MIX_MIN;
         else
            rsp_ff.mixed_sample <= sum_ext[23:0];
         rsp_ff.grain_count <= 5'(count_ff);
      end
   end

   assign status.slot_active = active_ff[slot];
   assign status.is_last     = (slot == highest_ff);
   assign status.div_done    = div_done;
   assign status.env_flat    = env_flat;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(active_ff)))
      else $error("active count out of step with active flags");

   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.launch && cmd.found |-> !active_ff[slot])
      else $error("launch into a busy slot marked free");

   a_launch_sets: assert property (@(posedge clock) disable iff (reset)
      cmd.launch |=> active_ff[$past(slot)] && !pending_ff[$past(slot)])
      else $error("launched grain not active or still pending");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

endmodule

// ===== sv/gpm_ctrl.sv =====
// Controller: sequences launch scan and the per-grain mix steps.
module gpm_ctrl #(
   parameter int GRAIN_SLOTS = 16,
   parameter int SLOT_W      = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_tick,
   input  logic                      req_launch,
   input  gpm_pkg::ctrl_status_type  status,
   output logic                      busy,
   output gpm_pkg::ctrl_cmd_type     cmd,
   output logic [SLOT_W-1:0]         slot
);

   gpm_pkg::state_type   state_ff, state_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 found_ff, found_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gpm_pkg::ST_IDLE;
         slot_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         found_ff <= found_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      found_in = found_ff;
      cmd      = '0;
      case (state_ff)
         gpm_pkg::ST_IDLE: begin
            if (start) begin
               if (req_tick == gpm_pkg::CMD_TICK) begin
                  cmd.take_tick = 1'b1;
                  cmd.sum_clear = 1'b1;
                  slot_in       = '0;
                  state_in      = req_launch ? gpm_pkg::ST_SCAN : gpm_pkg::ST_CHECK;
               end else begin
                  cmd.store_wr = 1'b1;
               end
            end
         end
         gpm_pkg::ST_SCAN: begin
            if (!status.slot_active) begin
               found_in = 1'b1;
               state_in = gpm_pkg::ST_LAUNCH;
            end else if (slot_ff == SLOT_W'(GRAIN_SLOTS - 1)) begin
               // no free slot: take slot 0
               found_in = 1'b0;
               slot_in  = '0;
               state_in = gpm_pkg::ST_LAUNCH;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         gpm_pkg::ST_LAUNCH: begin
            cmd.launch = 1'b1;
            cmd.found  = found_ff;
            slot_in    = '0;
            state_in   = gpm_pkg::ST_CHECK;
         end
         gpm_pkg::ST_CHECK: begin
            if (status.slot_active) begin
               cmd.grain_rd = 1'b1;
               state_in     = gpm_pkg::ST_LOAD;
            end else if (status.is_last) begin
               state_in = gpm_pkg::ST_DONE;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         gpm_pkg::ST_LOAD: begin
            cmd.div_pos = 1'b1;
            state_in    = gpm_pkg::ST_ADDR;
         end
         gpm_pkg::ST_ADDR: begin
            if (status.div_done) begin
               cmd.store_rd = 1'b1;
               cmd.div_wrap = 1'b1;
               state_in     = gpm_pkg::ST_WRAP;
            end
         end
         gpm_pkg::ST_WRAP: begin
            if (status.div_done) begin
               cmd.wrap_take = 1'b1;
               state_in      = gpm_pkg::ST_ENVP;
            end
         end
         gpm_pkg::ST_ENVP: begin
            cmd.env_prep = 1'b1;
            state_in     = gpm_pkg::ST_ENV;
         end
         gpm_pkg::ST_ENV: begin
            cmd.env_start = 1'b1;
            state_in      = status.env_flat ? gpm_pkg::ST_MUL : gpm_pkg::ST_FRAC;
         end
         gpm_pkg::ST_FRAC: begin
            if (status.div_done) begin
               cmd.weight_take = 1'b1;
               state_in        = gpm_pkg::ST_MUL;
            end
         end
         gpm_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = gpm_pkg::ST_ACC;
         end
         gpm_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
            if (status.is_last) begin
               state_in = gpm_pkg::ST_DONE;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = gpm_pkg::ST_CHECK;
            end
         end
         gpm_pkg::ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = gpm_pkg::ST_IDLE;
         end
         default: state_in = gpm_pkg::ST_IDLE;
      endcase
   end

   assign busy = (state_ff != gpm_pkg::ST_IDLE);
   assign slot = slot_ff;

endmodule

// ===== sv/granular_grain_pool_mixer_top.sv =====
// Top level of the granular grain pool mixer.
// A write word (cmd low) stores one sample and leaves busy low. A tick word (cmd high) raises
// busy until its result: a finish step, plus a free slot scan when launch is set, plus a check
// of each inactive slot from slot 0 up to the highest used slot and the mix steps of each
// active grain. All reductions and envelope ramps run through one shared bit-serial divider:
// an active grain takes longer when its store address needs reducing by the buffer length,
// when its stepped window offset has a magnitude of at least the window length, and while it
// is on a ramp. The result strobe rsp_valid lasts one cycle, comes in the cycle busy falls, and
// cannot be held off; the sample store and grain records need no clearing after reset.
module granular_grain_pool_mixer_top #(
   parameter int GRAIN_SLOTS = 16,
   parameter int STORE_DEPTH = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gpm_pkg::req_type req_data,
   output logic             rsp_valid,
   output gpm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_idx,
   input  logic [16:0]      csr_wdata
);

   localparam int SLOT_W = (GRAIN_SLOTS > 1) ? $clog2(GRAIN_SLOTS) : 1;

   gpm_pkg::ctrl_cmd_type    cmd;
   gpm_pkg::ctrl_status_type status;
   logic [SLOT_W-1:0]        slot;

   gpm_ctrl #(
      .GRAIN_SLOTS (GRAIN_SLOTS),
      .SLOT_W      (SLOT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_tick   (req_data.cmd),
      .req_launch (req_data.launch),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd),
      .slot       (slot)
   );

   gpm_dp #(
      .GRAIN_SLOTS (GRAIN_SLOTS),
      .STORE_DEPTH (STORE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SLOT_W      (SLOT_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .slot      (slot),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/granular_grain_pool_mixer_top_test.sv =====
// Testbench of the granular grain pool mixer: random words checked against a grain pool predictor.
module granular_grain_pool_mixer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   gpm_pkg::req_type  req_data;
   logic              rsp_valid;
   gpm_pkg::rsp_type  rsp_data;
   logic              csr_we;
   logic [1:0]        csr_idx;
   logic [16:0]       csr_wdata;

   granular_grain_pool_mixer_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic signed [15:0] store_mem [65536];
   bit          g_active [16];
   bit          g_stop [16];
   logic [15:0] g_start [16];
   logic [15:0] g_len [16];
   logic [17:0] g_pos [16];
   logic [5:0]  g_att [16];
   logic [5:0]  g_rel [16];
   logic [4:0]  g_step [16];
   int          highest_slot;
   logic [5:0]  cfg_att;
   logic [5:0]  cfg_rel;
   logic [4:0]  cfg_step;
   logic [16:0] cfg_blen;

   gpm_pkg::req_type pending_words [$];
   gpm_pkg::rsp_type mix_expected [$];
   int      mismatches;
   int      errors;
   bit      hold;
   int      burst_left;
   int      gap_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("granular_grain_pool_mixer_top_test: FAIL");
      $finish;
   end

   function automatic longint unsigned env_weight(longint unsigned off, longint unsigned len,
                                                   longint unsigned att, longint unsigned rel);
      longint unsigned pos;
      pos = 100 * off;
      if (att > 0 && pos < att * len) return (32768 * pos) / (att * len);
      if (rel > 0 && pos > (100 - rel) * len) return (32768 * (100 * len - pos)) / (rel * len);
      return 32768;
   endfunction

   // advance the grain pool by one accepted word; ticks queue their mix
   task automatic apply_word(input gpm_pkg::req_type w);
      int               slot;
      longint           blen, len, raw, off, sum, prod;
      int               cnt;
      gpm_pkg::rsp_type r;
      if (w.cmd == gpm_pkg::CMD_WRITE) begin
         store_mem[w.write_address] = w.write_sample;
         return;
      end
      if (w.launch) begin
         slot = 0;
         for (int i = 0; i < 16; i++) begin
            if (!g_active[i]) begin
               slot = i;
               if (i > highest_slot) highest_slot = i;
               break;
            end
         end
         g_len[slot] = (w.grain_length == 0) ? 16'd1 : w.grain_length;
         g_start[slot] = w.grain_start;
         g_pos[slot] = {2'b00, w.grain_start};
         g_att[slot] = cfg_att;
         g_rel[slot] = cfg_rel;
         g_step[slot] = cfg_step;
         g_active[slot] = 1;
         g_stop[slot] = 0;
         for (int i = 0; i <= highest_slot; i++)
            if (i != slot && g_active[i]) g_stop[i] = 1;
      end
      blen = cfg_blen;
      if (blen == 0) blen = 1;
      if (blen > 65536) blen = 65536;
      sum = 0;
      for (int i = 0; i <= highest_slot; i++) begin
         if (!g_active[i]) continue;
         prod = store_mem[longint'(g_pos[i]) % blen];
         len = g_len[i];
         raw = longint'(g_pos[i]) - longint'(g_start[i]) + longint'($signed(g_step[i]));
         off = ((raw % len) + len) % len;
         if ((raw >= len || raw < 0) && g_stop[i]) g_active[i] = 0;
         g_pos[i] = 18'(longint'(g_start[i]) + off);
         prod = prod * longint'(env_weight(off, len, g_att[i], g_rel[i]));
         sum += prod >>> 15;
      end
      if (sum > 8388607) sum = 8388607;
      if (sum < -8388608) sum = -8388608;
      cnt = 0;
      for (int i = 0; i < 16; i++) if (g_active[i]) cnt++;
      r.mixed_sample = 24'(sum);
      r.grain_count = 5'(cnt);
      mix_expected.push_back(r);
   endtask

   // driver: bursts of words with random gaps
   always @(posedge clock) begin
      gpm_pkg::req_type nxt;
      if (reset) begin
         start <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (start && !busy) apply_word(req_data);
         if (start && busy) begin
            // hold the word until taken
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (!hold && pending_words.size() > 0) begin
            nxt = pending_words.pop_front();
            req_data <= nxt;
            start <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each mix word with the oldest prediction
   always @(posedge clock) begin
      gpm_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (mix_expected.size() == 0) begin
            errors++;
            if (mismatches < 10) $display("unexpected result %p", rsp_data);
            mismatches++;
         end else begin
            e = mix_expected.pop_front();
            if (rsp_data.mixed_sample !== e.mixed_sample ||
                rsp_data.grain_count !== e.grain_count) begin
               errors++;
               if (mismatches < 10)
                  $display("mismatch: expected mix %0d grains %0d, got mix %0d grains %0d",
                           e.mixed_sample, e.grain_count,
                           rsp_data.mixed_sample, rsp_data.grain_count);
               mismatches++;
            end
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [16:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         gpm_pkg::CSR_ATTACK:  cfg_att = val[5:0];
         gpm_pkg::CSR_RELEASE: cfg_rel = val[5:0];
         gpm_pkg::CSR_STEP:    cfg_step = val[4:0];
         default:              cfg_blen = val;
      endcase
   endtask

   task automatic drain;
      hold = 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      @(posedge clock);
      while (mix_expected.size() != 0 || busy || start) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic gpm_pkg::req_type rand_word(input bit tick, input bit launch,
                                                  input int len);
      gpm_pkg::req_type w;
      w = gpm_pkg::req_type'({$urandom, $urandom});
      w.cmd = tick ? gpm_pkg::CMD_TICK : gpm_pkg::CMD_WRITE;
      w.launch = launch;
      w.grain_length = 16'(len);
      return w;
   endfunction

   // keep grain windows inside the two filled store regions
   function automatic logic [15:0] pick_start();
      if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 207));
      return 16'($urandom_range(65280, 65535));
   endfunction

   // long windows only while the buffer length keeps every read inside the low region
   task automatic add_random(input int n, input bit allow_long);
      int               len;
      gpm_pkg::req_type w;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 30) begin
            pending_words.push_back(rand_word(0, $urandom_range(0, 1), $urandom));
         end else begin
            if (allow_long && $urandom_range(0, 49) == 0)
               len = $urandom_range(0, 65535);
            else
               len = $urandom_range(1, 40);
            w = rand_word(1, $urandom_range(0, 99) < 20, len);
            w.grain_start = pick_start();
            pending_words.push_back(w);
         end
      end
   endtask

   initial begin
      gpm_pkg::req_type w;
      for (int i = 0; i < 16; i++) begin
         g_active[i] = 0;
         g_stop[i] = 0;
      end
      highest_slot = 0;
      cfg_att = gpm_pkg::ATTACK_RESET;
      cfg_rel = gpm_pkg::RELEASE_RESET;
      cfg_step = gpm_pkg::STEP_RESET;
      cfg_blen = gpm_pkg::BLEN_RESET;
      mismatches = 0;
      errors = 0;
      hold = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill the bottom and top 256 store words that grains may read
      for (int a = 0; a < 512; a++) begin
         w = rand_word(0, $urandom_range(0, 1), $urandom);
         w.write_address = (a < 256) ? 16'(a) : 16'(65024 + a);
         if (a == 0) w.write_sample = 16'sh7FFF;
         if (a == 511) w.write_sample = 16'sh8000;
         pending_words.push_back(w);
      end
      drain();

      // directed: empty tick, zero length, window past the store end, pool overflow
      pending_words.push_back(rand_word(1, 0, 5));
      w = rand_word(1, 1, 0);
      w.grain_start = pick_start();
      pending_words.push_back(w);
      w = rand_word(1, 1, 40);
      w.grain_start = 16'hFFFF;
      pending_words.push_back(w);
      w = rand_word(1, 1, 1);
      w.grain_start = 16'h0000;
      pending_words.push_back(w);
      for (int k = 0; k < 17; k++) begin
         w = rand_word(1, 1, $urandom_range(1, 40));
         w.grain_start = pick_start();
         pending_words.push_back(w);
      end
      pending_words.push_back(rand_word(1, 0, 3));
      drain();

      write_csr(gpm_pkg::CSR_ATTACK, 17'd49);
      write_csr(gpm_pkg::CSR_RELEASE, 17'd49);
      write_csr(gpm_pkg::CSR_STEP, 17'd8);
      write_csr(gpm_pkg::CSR_BLEN, 17'd65536);
      add_random(236, 1'b0);
      drain();

      write_csr(gpm_pkg::CSR_ATTACK, 17'd10);
      write_csr(gpm_pkg::CSR_RELEASE, 17'd30);
      write_csr(gpm_pkg::CSR_STEP, 17'h18);
      write_csr(gpm_pkg::CSR_BLEN, 17'h1FFFF);
      add_random(236, 1'b0);
      drain();

      write_csr(gpm_pkg::CSR_ATTACK, 17'd0);
      write_csr(gpm_pkg::CSR_RELEASE, 17'd0);
      write_csr(gpm_pkg::CSR_STEP, 17'h10);
      write_csr(gpm_pkg::CSR_BLEN, 17'd1);
      w = rand_word(1, 1, 65535);
      w.grain_start = 16'hFFFF;
      pending_words.push_back(w);
      w = rand_word(1, 1, 0);
      w.grain_start = pick_start();
      pending_words.push_back(w);
      add_random(236, 1'b1);
      drain();

      write_csr(gpm_pkg::CSR_ATTACK, 17'd63);
      write_csr(gpm_pkg::CSR_RELEASE, 17'd63);
      write_csr(gpm_pkg::CSR_STEP, 17'h0F);
      write_csr(gpm_pkg::CSR_BLEN, 17'd0);
      add_random(236, 1'b1);
      drain();

      for (int p = 0; p < 2; p++) begin
         write_csr(gpm_pkg::CSR_ATTACK, 17'($urandom_range(0, 63)));
         write_csr(gpm_pkg::CSR_RELEASE, 17'($urandom_range(0, 63)));
         write_csr(gpm_pkg::CSR_STEP, 17'($urandom_range(0, 31)));
         write_csr(gpm_pkg::CSR_BLEN, 17'($urandom_range(1, 256)));
         add_random(236, 1'b1);
         drain();
      end

      if (mix_expected.size() != 0) errors++;
      if (errors == 0) begin
         $display("granular_grain_pool_mixer_top_test: PASS");
      end else begin
         $display("granular_grain_pool_mixer_top_test: FAIL");
      end
      $finish;
   end
endmodule

// ===== files.f =====
sv/gpm_pkg.sv
sv/gpm_div.sv
sv/gpm_dp.sv
sv/gpm_ctrl.sv
sv/granular_grain_pool_mixer_top.sv
bench/granular_grain_pool_mixer_top_test.sv
